// File: design/zc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package zc_pkg;

	// Configuration register indexes
	localparam logic CFG_ROOT = 1'b0;
	localparam logic CFG_LEN  = 1'b1;

	// Quadrant codes of the phase word
	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	// Q30 arithmetic
	localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [60:0] ROUND_Q30   = 61'h2000_0000;

	localparam int HORNER_STEPS = 7;
	localparam int SIN_STEPS    = 6;

	// Taylor divisors become exact reciprocals: floor(p/d) = (p*M) >> SH
	// for every 32-bit p, with M = ceil(2^SH / d) and SH = 32 + ceil(log2 d).
	localparam logic [63:0] COS_M [HORNER_STEPS] = '{
		((64'd1 << 40) + 64'd181) / 64'd182,
		((64'd1 << 40) + 64'd131) / 64'd132,
		((64'd1 << 39) + 64'd89) / 64'd90,
		((64'd1 << 38) + 64'd55) / 64'd56,
		((64'd1 << 37) + 64'd29) / 64'd30,
		((64'd1 << 36) + 64'd11) / 64'd12,
		((64'd1 << 33) + 64'd1) / 64'd2
	};
	localparam int COS_SH [HORNER_STEPS] = '{40, 40, 39, 38, 37, 36, 33};

	localparam logic [63:0] SIN_M [HORNER_STEPS] = '{
		((64'd1 << 40) + 64'd155) / 64'd156,
		((64'd1 << 39) + 64'd109) / 64'd110,
		((64'd1 << 39) + 64'd71) / 64'd72,
		((64'd1 << 38) + 64'd41) / 64'd42,
		((64'd1 << 37) + 64'd19) / 64'd20,
		((64'd1 << 35) + 64'd5) / 64'd6,
		64'd0
	};
	localparam int SIN_SH [HORNER_STEPS] = '{40, 39, 39, 38, 37, 35, 0};

	// Sideband that rides along the sine/cosine pipeline
	typedef struct packed {
		logic        err;
		logic [1:0]  quad;
		logic [30:0] x;
		logic [31:0] x2;
	} zc_ctl_t;

endpackage

`default_nettype wire

// File: design/zadoff_chu_generator_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                 Word
// index     idx_valid / idx_ready     sample_index
// sample    smp_valid / smp_ready     sample_re, sample_im, index_error
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One index enters per clock unless the sample side stalls; its sample passes
// an input register, 24 + 12 + 32 stages of restoring modulo/division with a
// product register ahead of the second and third, and 18 stages of sine/cosine.
// Reset clears the configuration to root 1, length 63 and empties the pipe.
// A stall on the sample side holds every stage at once; the last stage is
// the output register, so no word is dropped or repeated.
module zadoff_chu_generator_core
	import zc_pkg::*;
#(
	parameter int MAX_LENGTH  = 4096,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic                   cfg_index,
	input  wire logic [12:0]            cfg_data,
	input  wire logic                   idx_valid,
	output logic                        idx_ready,
	input  wire logic [11:0]            sample_index,
	output logic                        smp_valid,
	input  wire logic                   smp_ready,
	output logic [SAMPLE_BITS-1:0]      sample_re,
	output logic [SAMPLE_BITS-1:0]      sample_im,
	output logic                        index_error
);

	localparam int LW = $clog2(MAX_LENGTH + 1);  // length
	localparam int DW = LW + 1;                   // 2 * length
	localparam int PW = DW + 12;                  // remainder times root
	localparam int NW = DW + 32;                  // phase dividend

	logic [11:0] root_index_q;
	logic [12:0] seq_length_q;

	logic          en;
	logic [LW-1:0] len;
	logic [DW-1:0] den;
	logic          err_in;
	logic [23:0]   m_in;

	logic          v_s1;
	logic          err_s1;
	logic [23:0]   m_s1;

	logic          a_valid;
	logic          a_err;
	logic [DW-1:0] a_rem;
	logic [23:0]   a_quo;

	logic          v_s2;
	logic          err_s2;
	logic [PW-1:0] prod_s2;

	logic          b_valid;
	logic          b_err;
	logic [DW-1:0] b_rem;
	logic [11:0]   b_quo;

	logic          v_s3;
	logic          err_s3;
	logic [NW-1:0] num_s3;

	logic          c_valid;
	logic          c_err;
	logic [DW-1:0] c_rem;
	logic [31:0]   c_quo;

	// Advance the whole pipe unless the output word is held.
	assign en        = !smp_valid || smp_ready;
	assign idx_ready = en;
	assign cfg_ready = 1'b1;

	// Clamp the length to the built maximum.
	assign len = (32'(seq_length_q) > 32'(MAX_LENGTH)) ? LW'(MAX_LENGTH)
	                                                    : LW'(seq_length_q);
	assign den = {len, 1'b0};

	assign err_in = (len == '0) || (32'(sample_index) >= 32'(len));
	assign m_in   = 24'(sample_index) * (24'(sample_index) + 24'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_index_q <= 12'd1;
			seq_length_q <= 13'd63;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ROOT: root_index_q <= cfg_data[11:0];
				CFG_LEN:  seq_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= idx_valid;
			v_s2 <= a_valid;
			v_s3 <= b_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s1  <= err_in;
			m_s1    <= m_in;
			err_s2  <= a_err;
			prod_s2 <= PW'(a_rem) * PW'(root_index_q);
			err_s3  <= b_err;
			num_s3  <= {b_rem, 32'd0} + NW'(len);
		end
	end

	// n*(n+1) mod 2N
	zc_divpipe #(
		.NUM_W (24),
		.DEN_W (DW),
		.STEPS (24)
	) u_mod_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.in_err    (err_s1),
		.in_num    (m_s1),
		.den       (den),
		.out_valid (a_valid),
		.out_err   (a_err),
		.out_rem   (a_rem),
		.out_quo   (a_quo)
	);

	// times root, mod 2N: quotient stays below the 12-bit root
	zc_divpipe #(
		.NUM_W (PW),
		.DEN_W (DW),
		.STEPS (12)
	) u_mod_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.in_err    (err_s2),
		.in_num    (prod_s2),
		.den       (den),
		.out_valid (b_valid),
		.out_err   (b_err),
		.out_rem   (b_rem),
		.out_quo   (b_quo)
	);

	// phase word: (k * 2^32 + N) / 2N, a 32-bit fraction of a turn
	zc_divpipe #(
		.NUM_W (NW),
		.DEN_W (DW),
		.STEPS (32)
	) u_phase (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.in_err    (err_s3),
		.in_num    (num_s3),
		.den       (den),
		.out_valid (c_valid),
		.out_err   (c_err),
		.out_rem   (c_rem),
		.out_quo   (c_quo)
	);

	zc_sincos #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_sincos (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (c_valid),
		.in_err    (c_err),
		.phase     (c_quo),
		.out_valid (smp_valid),
		.out_err   (index_error),
		.out_re    (sample_re),
		.out_im    (sample_im)
	);

endmodule

`default_nettype wire

// File: design/zc_divpipe.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per stage.
module zc_divpipe
	import zc_pkg::*;
#(
	parameter int NUM_W = 24,
	parameter int DEN_W = 14,
	parameter int STEPS = 24
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_valid,
	input  wire logic             in_err,
	input  wire logic [NUM_W-1:0] in_num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  out_valid,
	output logic                  out_err,
	output logic [DEN_W-1:0]      out_rem,
	output logic [STEPS-1:0]      out_quo
);

	localparam int W = NUM_W + DEN_W;

	logic [STEPS-1:0] v_s;
	logic [STEPS-1:0] err_s;
	logic [NUM_W-1:0] rem_s [STEPS];
	logic [STEPS-1:0] quo_s [STEPS];
	logic [NUM_W-1:0] rem_n [STEPS];
	logic [STEPS-1:0] quo_n [STEPS];

	always_comb begin
		logic [NUM_W-1:0] rem_in;
		logic [STEPS-1:0] quo_in;
		logic [W-1:0]     den_sh;
		for (int i = 0; i < STEPS; i++) begin
			if (i == 0) begin
				rem_in = in_num;
				quo_in = '0;
			end else begin
				rem_in = rem_s[i-1];
				quo_in = quo_s[i-1];
			end
			den_sh = W'(den) << (STEPS - 1 - i);
			if (W'(rem_in) >= den_sh) begin
				rem_n[i] = NUM_W'(W'(rem_in) - den_sh);
				quo_n[i] = quo_in | (STEPS'(1) << (STEPS - 1 - i));
			end else begin
				rem_n[i] = rem_in;
				quo_n[i] = quo_in;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[STEPS-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s <= {err_s[STEPS-2:0], in_err};
			rem_s <= rem_n;
			quo_s <= quo_n;
		end
	end

	assign out_valid = v_s[STEPS-1];
	assign out_err   = err_s[STEPS-1];
	assign out_rem   = DEN_W'(rem_s[STEPS-1]);
	assign out_quo   = quo_s[STEPS-1];

endmodule

`default_nettype wire

// File: design/zc_sincos.sv
`timescale 1ns / 1ps
`default_nettype none

// Phase word to (cos, -sin) by Horner-form Taylor series.
module zc_sincos
	import zc_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire logic                   in_valid,
	input  wire logic                   in_err,
	input  wire logic [31:0]            phase,
	output logic                        out_valid,
	output logic                        out_err,
	output logic [SAMPLE_BITS-1:0]      out_re,
	output logic [SAMPLE_BITS-1:0]      out_im
);

	localparam int SH = 31 - SAMPLE_BITS;
	localparam logic [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [31:0] OUT_RND = 32'd1 << (SH - 1);

	function automatic logic [SAMPLE_BITS-1:0] to_out(input logic [30:0] v);
		logic [30:0] vc;
		logic [31:0] sum;
		logic [SAMPLE_BITS:0] r;
		vc  = (v > Q30_ONE) ? Q30_ONE : v;
		sum = 32'(vc) + OUT_RND;
		r   = (SAMPLE_BITS+1)'(sum >> SH);
		return (r > (SAMPLE_BITS+1)'(OUT_MAX)) ? OUT_MAX : SAMPLE_BITS'(r);
	endfunction

	logic        v_s1;
	logic        err_s1;
	logic [1:0]  quad_s1;
	logic [30:0] x_s1;
	logic        v_s2;
	zc_ctl_t     ctl_s2;

	logic [HORNER_STEPS-1:0] va;
	logic [HORNER_STEPS-1:0] vb;
	zc_ctl_t     ca [HORNER_STEPS];
	zc_ctl_t     cb [HORNER_STEPS];
	logic [31:0] pc_a [HORNER_STEPS];
	logic [31:0] ps_a [HORNER_STEPS];
	logic [30:0] tc_b [HORNER_STEPS];
	logic [30:0] ts_b [HORNER_STEPS];
	zc_ctl_t     ca_n [HORNER_STEPS];
	logic [31:0] pc_n [HORNER_STEPS];
	logic [31:0] ps_n [HORNER_STEPS];
	logic [30:0] tc_n [HORNER_STEPS];
	logic [30:0] ts_n [HORNER_STEPS];

	logic        v_s3;
	logic        err_s3;
	logic [1:0]  quad_s3;
	logic [30:0] s_s3;
	logic [30:0] c_s3;

	logic        v_s4;
	logic        err_s4;
	logic [SAMPLE_BITS-1:0] re_s4;
	logic [SAMPLE_BITS-1:0] im_s4;

	logic [60:0] x_full;
	logic [SAMPLE_BITS-1:0] sv;
	logic [SAMPLE_BITS-1:0] cv;
	logic [SAMPLE_BITS-1:0] re_n;
	logic [SAMPLE_BITS-1:0] im_n;

	assign x_full = 61'(phase[29:0]) * 61'(HALF_PI_Q30) + ROUND_Q30;

	// Each Horner slot: multiply by x^2, then divide by the Taylor divisor
	// through its reciprocal and subtract from one, floored at zero.
	always_comb begin
		zc_ctl_t     c_in;
		logic [30:0] tc_in;
		logic [30:0] ts_in;
		logic [31:0] qc;
		logic [31:0] qs;
		for (int j = 0; j < HORNER_STEPS; j++) begin
			if (j == 0) begin
				c_in  = ctl_s2;
				tc_in = Q30_ONE;
				ts_in = Q30_ONE;
			end else begin
				c_in  = cb[j-1];
				tc_in = tc_b[j-1];
				ts_in = ts_b[j-1];
			end
			ca_n[j] = c_in;
			pc_n[j] = 32'((64'(c_in.x2) * 64'(tc_in)) >> 30);
			// sine series is one term shorter: its last slot just carries t
			if (j < SIN_STEPS) begin
				ps_n[j] = 32'((64'(c_in.x2) * 64'(ts_in)) >> 30);
			end else begin
				ps_n[j] = 32'(ts_in);
			end

			qc = 32'((66'(pc_a[j]) * 66'(COS_M[j])) >> COS_SH[j]);
			tc_n[j] = (qc >= 32'(Q30_ONE)) ? '0 : 31'(32'(Q30_ONE) - qc);
			if (j < SIN_STEPS) begin
				qs = 32'((66'(ps_a[j]) * 66'(SIN_M[j])) >> SIN_SH[j]);
				ts_n[j] = (qs >= 32'(Q30_ONE)) ? '0 : 31'(32'(Q30_ONE) - qs);
			end else begin
				qs = '0;
				ts_n[j] = ps_a[j][30:0];
			end
		end
	end

	assign sv = to_out(s_s3);
	assign cv = to_out(c_s3);

	always_comb begin
		case (quad_s3)
			QUAD_0: begin
				re_n = cv;
				im_n = SAMPLE_BITS'(0) - sv;
			end
			QUAD_1: begin
				re_n = SAMPLE_BITS'(0) - sv;
				im_n = SAMPLE_BITS'(0) - cv;
			end
			QUAD_2: begin
				re_n = SAMPLE_BITS'(0) - cv;
				im_n = sv;
			end
			default: begin
				re_n = sv;
				im_n = cv;
			end
		endcase
		if (err_s3) begin
			re_n = '0;
			im_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			va   <= '0;
			vb   <= '0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			va   <= {vb[HORNER_STEPS-2:0], v_s2};
			vb   <= va;
			v_s3 <= vb[HORNER_STEPS-1];
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s1      <= in_err;
			quad_s1     <= phase[31:30];
			x_s1        <= 31'(x_full >> 30);
			ctl_s2.err  <= err_s1;
			ctl_s2.quad <= quad_s1;
			ctl_s2.x    <= x_s1;
			ctl_s2.x2   <= 32'((62'(x_s1) * 62'(x_s1)) >> 30);
			ca          <= ca_n;
			pc_a        <= pc_n;
			ps_a        <= ps_n;
			cb          <= ca;
			tc_b        <= tc_n;
			ts_b        <= ts_n;
			err_s3      <= cb[HORNER_STEPS-1].err;
			quad_s3     <= cb[HORNER_STEPS-1].quad;
			s_s3        <= 31'((62'(cb[HORNER_STEPS-1].x) * 62'(ts_b[HORNER_STEPS-1])) >> 30);
			c_s3        <= tc_b[HORNER_STEPS-1];
			err_s4      <= err_s3;
			re_s4       <= re_n;
			im_s4       <= im_n;
		end
	end

	assign out_valid = v_s4;
	assign out_err   = err_s4;
	assign out_re    = re_s4;
	assign out_im    = im_s4;

endmodule

`default_nettype wire

// File: dv/tb_zadoff_chu_generator_core.sv
`timescale 1ns / 1ps

// Testbench for the Zadoff-Chu sample generator.
// Drive sample indexes through the index channel, predict each sample with an
// integer model of the phase/Taylor pipeline, and compare every word that
// leaves the sample channel against the oldest prediction.
module tb_zadoff_chu_generator_core;
	import zc_pkg::*;

	localparam int MAX_LEN     = 4096;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 120;

	typedef struct packed {
		logic [15:0] re;
		logic [15:0] im;
		logic        err;
	} zc_sample_t;

	localparam longint unsigned ONE_Q30  = 64'd1 << 30;
	localparam longint unsigned HALF_PI  = 64'd1686629713;
	localparam longint unsigned SIN_DIV [6] = '{156, 110, 72, 42, 20, 6};
	localparam longint unsigned COS_DIV [7] = '{182, 132, 90, 56, 30, 12, 2};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_ROOT;
	logic [12:0] cfg_data = '0;
	logic        idx_valid = 1'b0;
	logic        idx_ready;
	logic [11:0] sample_index = '0;
	logic        smp_valid;
	logic        smp_ready = 1'b0;
	logic [15:0] sample_re;
	logic [15:0] sample_im;
	logic        index_error;

	// Predictor copy of the configuration
	logic [11:0] zc_root = 12'd1;
	logic [12:0] zc_len  = 13'd63;

	logic [11:0] index_pending_q [$];
	zc_sample_t  sample_expect_q [$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int mismatches     = 0;
	int cycles         = 0;

	zadoff_chu_generator_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.idx_valid    (idx_valid),
		.idx_ready    (idx_ready),
		.sample_index (sample_index),
		.smp_valid    (smp_valid),
		.smp_ready    (smp_ready),
		.sample_re    (sample_re),
		.sample_im    (sample_im),
		.index_error  (index_error)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Horner-form Taylor polynomial in x^2, each product truncated then
	// divided with truncation; clamp at zero after every step.
	function automatic longint unsigned taylor_horner(longint unsigned x2, bit use_cos);
		longint unsigned t;
		longint unsigned prod;
		longint unsigned dv;
		int steps;
		t = ONE_Q30;
		steps = use_cos ? 7 : 6;
		for (int i = 0; i < steps; i++) begin
			dv = use_cos ? COS_DIV[i] : SIN_DIV[i];
			prod = (x2 * t) >> 30;
			t = (prod / dv > ONE_Q30) ? 64'd0 : ONE_Q30 - prod / dv;
		end
		return t;
	endfunction

	// Q30 magnitude to a Q1.15 code, rounded, +1.0 saturated
	function automatic logic [15:0] q30_to_code(longint unsigned v);
		longint unsigned r;
		if (v > ONE_Q30)
			v = ONE_Q30;
		r = (v + (64'd1 << 14)) >> 15;
		return (r > 64'd32767) ? 16'h7fff : r[15:0];
	endfunction

	function automatic zc_sample_t predict_sample(logic [11:0] n_in);
		zc_sample_t res;
		longint unsigned n, len, two_n, k, phase, r, x, x2, s, c;
		logic [15:0] sc, cc;
		logic [1:0] quad;
		n = n_in;
		len = (zc_len > MAX_LEN) ? MAX_LEN : zc_len;
		res = '0;
		if (len == 0 || n >= len) begin
			res.err = 1'b1;
			return res;
		end
		two_n = 2 * len;
		k = ((n * (n + 1)) % two_n) * (longint'(zc_root) % two_n) % two_n;
		phase = (((k << 32) + len) / two_n) & 64'hffff_ffff;
		quad = phase[31:30];
		r = phase & 64'h3fff_ffff;
		x = (r * HALF_PI + (64'd1 << 29)) >> 30;
		x2 = (x * x) >> 30;
		s = (x * taylor_horner(x2, 1'b0)) >> 30;
		c = taylor_horner(x2, 1'b1);
		sc = q30_to_code(s);
		cc = q30_to_code(c);
		// Quadrant picks signs and may swap sine and cosine
		case (quad)
			QUAD_0: begin
				res.re = cc;
				res.im = -sc;
			end
			QUAD_1: begin
				res.re = -sc;
				res.im = -cc;
			end
			QUAD_2: begin
				res.re = -cc;
				res.im = sc;
			end
			default: begin
				res.re = sc;
				res.im = cc;
			end
		endcase
		return res;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// Write one register; the block is idle whenever this is called
	task automatic write_reg(logic idx, logic [12:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_ROOT)
			zc_root = data[11:0];
		else
			zc_len = data;
	endtask

	// Hold until every queued index went in and every sample came back
	task automatic drain_pipe();
		while (index_pending_q.size() != 0 || idx_valid || sample_expect_q.size() != 0)
			@(posedge clk);
	endtask

	// Mostly in-range indexes (the interesting part); some out of range
	function automatic logic [11:0] pick_index();
		int lim;
		lim = (zc_len > MAX_LEN) ? MAX_LEN : zc_len;
		if (lim > 0 && $urandom_range(99) < 80)
			return 12'($urandom_range(lim - 1, 0));
		return 12'($urandom_range(4095, 0));
	endfunction

	function automatic logic [12:0] pick_length();
		case ($urandom_range(9))
			0: return 13'd0;
			1: return 13'd1;
			2: return 13'd4096;
			3: return 13'($urandom_range(8191, 4097));
			4, 5: return 13'($urandom_range(64, 2));
			default: return 13'($urandom_range(4096, 1));
		endcase
	endfunction

	// Driver: advance to the next index on accept, idle at random
	always @(posedge clk) begin
		logic        nxt_valid;
		logic [11:0] nxt_index;
		if (arst_n) begin
			nxt_valid = idx_valid;
			nxt_index = sample_index;
			if (idx_valid && idx_ready) begin
				sample_expect_q.push_back(predict_sample(sample_index));
				void'(index_pending_q.pop_front());
				nxt_valid = 1'b0;
			end
			if (!nxt_valid && index_pending_q.size() != 0
					&& $urandom_range(99) >= send_idle_pct) begin
				nxt_valid = 1'b1;
				nxt_index = index_pending_q[0];
			end
			idx_valid    <= nxt_valid;
			sample_index <= nxt_index;
		end
	end

	// Monitor: check each accepted word against the oldest prediction
	always @(posedge clk) begin
		zc_sample_t want;
		if (arst_n) begin
			if (smp_valid && smp_ready) begin
				if (sample_expect_q.size() == 0) begin
					report_mismatch("unexpected sample word", 1, 0);
				end else begin
					want = sample_expect_q.pop_front();
					if (sample_re !== want.re)
						report_mismatch("sample_re", $signed(sample_re), $signed(want.re));
					if (sample_im !== want.im)
						report_mismatch("sample_im", $signed(sample_im), $signed(want.im));
					if (index_error !== want.err)
						report_mismatch("index_error", index_error, want.err);
				end
			end
			smp_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int idle_mode;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset configuration: edges of the range and just past it
		index_pending_q = '{12'd0, 12'd1, 12'd62, 12'd63, 12'd4095};
		drain_pipe();

		// Largest root and length, extreme indexes
		write_reg(CFG_ROOT, 13'd4095);
		write_reg(CFG_LEN, 13'd4096);
		index_pending_q = '{12'd0, 12'd1, 12'd2048, 12'd4094, 12'd4095, 12'd1365};
		drain_pipe();

		// Root zero gives (max, 0); length one allows index 0 only
		write_reg(CFG_ROOT, 13'd0);
		write_reg(CFG_LEN, 13'd1);
		index_pending_q = '{12'd0, 12'd1};
		drain_pipe();

		// Length zero: everything out of range
		write_reg(CFG_LEN, 13'd0);
		index_pending_q = '{12'd0, 12'd5};
		drain_pipe();

		// Length above the maximum is clamped; root data carries bit 12
		write_reg(CFG_ROOT, 13'h1007);
		write_reg(CFG_LEN, 13'd8191);
		index_pending_q = '{12'd0, 12'd4095, 12'd1000, 12'd2222};
		drain_pipe();

		// Random phases: new configuration each, cycling the idle modes
		for (int ph = 0; ph < 12; ph++) begin
			write_reg(CFG_ROOT, 13'($urandom_range(8191, 0)));
			write_reg(CFG_LEN, pick_length());
			idle_mode = ph % 4;
			send_idle_pct  = (idle_mode == 1) ? 84 : (idle_mode == 3) ? 16 : 0;
			recv_stall_pct = (idle_mode == 2) ? 84 : (idle_mode == 3) ? 16 : 0;
			for (int i = 0; i < 54; i++)
				index_pending_q.push_back(pick_index());
			drain_pipe();
		end

		// Let any stray word surface
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0 && sample_expect_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
